>>> hw/rtl/yuvrgb_pkg.sv
package yuvrgb_pkg;

    localparam int SUM_W = 27;
    localparam int NUM_PIX = 4;

    typedef logic signed [SUM_W-1:0] sum_val_t;

    localparam sum_val_t LUMA_GAIN = 27'sd76309;
    localparam sum_val_t CR_TO_R = 27'sd104597;
    localparam sum_val_t CB_TO_G = 27'sd25675;
    localparam sum_val_t CR_TO_G = 27'sd53279;
    localparam sum_val_t CB_TO_B = 27'sd132201;
    localparam logic signed [8:0] LUMA_OFFSET = 9'sd16;
    localparam logic signed [8:0] CHROMA_MID = 9'sd128;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;
    localparam logic [7:0] CHAN_MAX = 8'hFF;
    localparam int FRAC_W = 16;

    typedef logic [NUM_PIX-1:0][7:0] luma_vec_t;

    typedef struct packed {
        sum_val_t [NUM_PIX-1:0] luma;
        sum_val_t r_off;
        sum_val_t gu;
        sum_val_t gv;
        sum_val_t b_off;
    } prod_t;

    typedef struct packed {
        sum_val_t [NUM_PIX-1:0] r;
        sum_val_t [NUM_PIX-1:0] g;
        sum_val_t [NUM_PIX-1:0] b;
    } sum_t;

    typedef logic [NUM_PIX-1:0][31:0] pix_vec_t;

endpackage

>>> hw/rtl/yuv420_block_to_rgba.sv
// channel | handshake            | payload
// in      | in_valid / in_ready   | luma_top_left .. luma_bottom_right, chroma_blue, chroma_red
// out     | out_valid / out_ready | pixel_top_left .. pixel_bottom_right (rgba words)
//
// one block beat per cycle while out_ready is high; beats pass the mult, sum and pack registers
// stages: constant multiplies, channel sums, saturate and pack
// rst_n clears the stage valid bits only, no data is reset
// each stage holds its beat while the next one is full and stalled
// in_ready drops only when all three stages are full and out_ready is low
module yuv420_block_to_rgba (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  luma_top_left,
    input  logic [7:0]  luma_top_right,
    input  logic [7:0]  luma_bottom_left,
    input  logic [7:0]  luma_bottom_right,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_top_left,
    output logic [31:0] pixel_top_right,
    output logic [31:0] pixel_bottom_left,
    output logic [31:0] pixel_bottom_right
);

    yuvrgb_pkg::luma_vec_t luma;
    yuvrgb_pkg::prod_t     prod;
    yuvrgb_pkg::sum_t      sums;
    yuvrgb_pkg::pix_vec_t  pixels;
    logic                  prod_valid;
    logic                  prod_ready;
    logic                  sum_valid;
    logic                  sum_ready;

    assign luma = {luma_bottom_right, luma_bottom_left, luma_top_right, luma_top_left};

    yuvrgb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .luma      (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod      (prod)
    );

    yuvrgb_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod      (prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .sums      (sums)
    );

    yuvrgb_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .sums      (sums),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixels    (pixels)
    );

    assign pixel_top_left = pixels[0];
    assign pixel_top_right = pixels[1];
    assign pixel_bottom_left = pixels[2];
    assign pixel_bottom_right = pixels[3];

`ifndef SYNTH
    a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_top_left[31:24] == yuvrgb_pkg::ALPHA_FULL
                       && pixel_bottom_right[31:24] == yuvrgb_pkg::ALPHA_FULL))
        else $error("alpha byte not full");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (prod_valid && sum_valid && out_valid && !out_ready))
        else $error("input stalled with room in pipeline");

    a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(sum_valid))
        else $error("output valid without a summed beat");

    a_sum_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_valid) |-> $past(prod_valid))
        else $error("sum valid without a product beat");
`endif

endmodule

>>> hw/rtl/yuvrgb_mult.sv
module yuvrgb_mult (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  yuvrgb_pkg::luma_vec_t luma,
    input  logic [7:0]            chroma_blue,
    input  logic [7:0]            chroma_red,
    output logic                  out_valid,
    input  logic                  out_ready,
    output yuvrgb_pkg::prod_t     prod
);

    logic              valid_reg;
    yuvrgb_pkg::prod_t prod_reg;
    yuvrgb_pkg::prod_t prod_next;
    logic signed [8:0] u_diff;
    logic signed [8:0] v_diff;
    logic signed [8:0] y_diff [yuvrgb_pkg::NUM_PIX];

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign prod = prod_reg;

    always_comb
    begin
        u_diff = $signed({1'b0, chroma_blue}) - yuvrgb_pkg::CHROMA_MID;
        v_diff = $signed({1'b0, chroma_red}) - yuvrgb_pkg::CHROMA_MID;
        for (int k = 0; k < yuvrgb_pkg::NUM_PIX; k++)
        begin
            y_diff[k] = $signed({1'b0, luma[k]}) - yuvrgb_pkg::LUMA_OFFSET;
            prod_next.luma[k] = yuvrgb_pkg::SUM_W'(y_diff[k]) * yuvrgb_pkg::LUMA_GAIN;
        end
        prod_next.r_off = yuvrgb_pkg::SUM_W'(v_diff) * yuvrgb_pkg::CR_TO_R;
        prod_next.gu = yuvrgb_pkg::SUM_W'(u_diff) * yuvrgb_pkg::CB_TO_G;
        prod_next.gv = yuvrgb_pkg::SUM_W'(v_diff) * yuvrgb_pkg::CR_TO_G;
        prod_next.b_off = yuvrgb_pkg::SUM_W'(u_diff) * yuvrgb_pkg::CB_TO_B;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> hw/rtl/yuvrgb_sum.sv
module yuvrgb_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  yuvrgb_pkg::prod_t prod,
    output logic              out_valid,
    input  logic              out_ready,
    output yuvrgb_pkg::sum_t  sums
);

    logic             valid_reg;
    yuvrgb_pkg::sum_t sums_reg;
    yuvrgb_pkg::sum_t sums_next;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign sums = sums_reg;

    always_comb
    begin
        for (int k = 0; k < yuvrgb_pkg::NUM_PIX; k++)
        begin
            sums_next.r[k] = $signed(prod.luma[k]) + $signed(prod.r_off);
            sums_next.g[k] = $signed(prod.luma[k]) - $signed(prod.gu) - $signed(prod.gv);
            sums_next.b[k] = $signed(prod.luma[k]) + $signed(prod.b_off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sums_reg <= sums_next;
        end
    end

endmodule

>>> hw/rtl/yuvrgb_pack.sv
module yuvrgb_pack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  yuvrgb_pkg::sum_t     sums,
    output logic                 out_valid,
    input  logic                 out_ready,
    output yuvrgb_pkg::pix_vec_t pixels
);

    logic                 valid_reg;
    yuvrgb_pkg::pix_vec_t pixels_reg;
    yuvrgb_pkg::pix_vec_t pixels_next;

    function automatic logic [7:0] sat_chan(input yuvrgb_pkg::sum_val_t sum);
        logic [7:0] res;
        if (sum[yuvrgb_pkg::SUM_W-1])
        begin
            res = 8'd0;
        end
        else if (|sum[yuvrgb_pkg::SUM_W-2:yuvrgb_pkg::FRAC_W+8])
        begin
            res = yuvrgb_pkg::CHAN_MAX;
        end
        else
        begin
            res = sum[yuvrgb_pkg::FRAC_W+7:yuvrgb_pkg::FRAC_W];
        end
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign pixels = pixels_reg;

    always_comb
    begin
        for (int k = 0; k < yuvrgb_pkg::NUM_PIX; k++)
        begin
            pixels_next[k] = {yuvrgb_pkg::ALPHA_FULL, sat_chan(sums.b[k]),
                              sat_chan(sums.g[k]), sat_chan(sums.r[k])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixels_reg <= pixels_next;
        end
    end

endmodule

>>> dv/yuv420_block_to_rgba_tb.sv
module yuv420_block_to_rgba_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Y_GAIN = 76309;
    localparam int Y_BLACK = 16;
    localparam int C_ZERO = 128;
    localparam int V_TO_RED = 104597;
    localparam int U_TO_GREEN = 25675;
    localparam int V_TO_GREEN = 53279;
    localparam int U_TO_BLUE = 132201;
    localparam int PIPE_DEPTH = 3;
    localparam int HOLD_CYCLES = 80;

    class block_scoreboard;
        yuvrgb_pkg::pix_vec_t pixels_due[$];
        int errors = 0;
        string pixel_name[4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

        function logic [7:0] clamp_channel(int sum);
            int q;
            if (sum < 0)
                return 8'h00;
            q = sum >>> 16;
            if (q > 255)
                return 8'hFF;
            return q[7:0];
        endfunction

        function logic [31:0] rgba_word(logic [7:0] y, int r_off, int g_off, int b_off);
            int base;
            base = Y_GAIN * (int'(y) - Y_BLACK);
            return {8'hFF, clamp_channel(base + b_off), clamp_channel(base + g_off),
                    clamp_channel(base + r_off)};
        endfunction

        function void note_block(logic [3:0][7:0] luma, logic [7:0] cb, logic [7:0] cr);
            int u;
            int v;
            yuvrgb_pkg::pix_vec_t want;
            u = int'(cb) - C_ZERO;
            v = int'(cr) - C_ZERO;
            for (int k = 0; k < 4; k++)
                want[k] = rgba_word(luma[k], V_TO_RED * v, -(U_TO_GREEN * u) - V_TO_GREEN * v,
                                    U_TO_BLUE * u);
            pixels_due.push_back(want);
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        task report(string msg);
            $display("%0d ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pixels(yuvrgb_pkg::pix_vec_t got);
            yuvrgb_pkg::pix_vec_t want;
            if (pixels_due.size() == 0)
            begin
                report($sformatf("output beat %h with nothing outstanding", got));
                return;
            end
            want = pixels_due.pop_front();
            for (int k = 0; k < 4; k++)
                if (got[k] !== want[k])
                    report($sformatf("pixel_%s got %h, expected %h",
                                     pixel_name[k], got[k], want[k]));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  luma_top_left = 8'h00;
    logic [7:0]  luma_top_right = 8'h00;
    logic [7:0]  luma_bottom_left = 8'h00;
    logic [7:0]  luma_bottom_right = 8'h00;
    logic [7:0]  chroma_blue = 8'h00;
    logic [7:0]  chroma_red = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;
    block_scoreboard sb;

    yuv420_block_to_rgba uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .luma_top_left      (luma_top_left),
        .luma_top_right     (luma_top_right),
        .luma_bottom_left   (luma_bottom_left),
        .luma_bottom_right  (luma_bottom_right),
        .chroma_blue        (chroma_blue),
        .chroma_red         (chroma_red),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus long hold-offs on request
    always
    begin
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_block({luma_bottom_right, luma_bottom_left, luma_top_right, luma_top_left},
                              chroma_blue, chroma_red);
            if (out_valid && out_ready)
                sb.check_pixels({pixel_bottom_right, pixel_bottom_left, pixel_top_right,
                                 pixel_top_left});
        end
    end

    task send_block(input logic [7:0] tl, input logic [7:0] tr, input logic [7:0] bl,
                    input logic [7:0] br, input logic [7:0] cb, input logic [7:0] cr);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        luma_top_left <= tl;
        luma_top_right <= tr;
        luma_bottom_left <= bl;
        luma_bottom_right <= br;
        chroma_blue <= cb;
        chroma_red <= cr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(1) ? 8'd16 : 8'd235;
            3: return 8'($urandom_range(140, 116));
            default: return 8'($urandom);
        endcase
    endfunction

    task send_random(input int count);
        for (int i = 0; i < count; i++)
            send_block(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       pick_sample(), pick_sample());
        in_valid <= 1'b0;
    endtask

    task drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
    endtask

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, black and white points, saturation both ways
        set_idling(0, 0);
        send_block(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_block(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128);
        send_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128);
        send_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd128, 8'd128);
        send_block(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_block(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_block(8'd128, 8'd128, 8'd128, 8'd128, 8'h00, 8'hFF);
        send_block(8'd128, 8'd128, 8'd128, 8'd128, 8'hFF, 8'h00);
        send_block(8'd15, 8'd16, 8'd17, 8'd128, 8'd127, 8'd129);
        send_block(8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hAA, 8'h55);
        send_block(8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55, 8'hAA);
        send_block(8'd235, 8'd16, 8'd240, 8'd10, 8'd16, 8'd240);
        send_block(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240);
        send_block(8'h01, 8'h80, 8'h7F, 8'hFE, 8'h01, 8'hFE);
        in_valid <= 1'b0;
        drain();

        set_idling(0, 0);
        send_random(110);
        drain();
        set_idling(68, 0);
        send_random(110);
        drain();
        set_idling(0, 68);
        send_random(110);
        drain();
        set_idling(30, 30);
        send_random(110);
        drain();

        // long receiver hold-off while the sender keeps pushing
        set_idling(0, 0);
        hold_seq <= hold_seq + 1;
        send_random(100);
        drain();

        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d beats never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
